/* rtl/tcw_pkg.sv */
// Shared types, codes and defaults of the text console writer.
package tcw_pkg;

  localparam int DEF_ROWS = 25;
  localparam int DEF_COLS = 80;

  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int IDX_W     = 11;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [BYTE_W-1:0] DEF_ATTR = 8'd15;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;

  typedef enum logic [1:0] {
    SWEEP_INIT,
    SWEEP_CLEAR,
    SWEEP_SCROLL
  } tcw_sweep_e;

  typedef struct packed {
    logic       in_load;
    logic       put_exec;
    logic       clear_cur;
    logic       sweep_start;
    tcw_sweep_e sweep_kind;
    logic       read_issue;
    logic       result_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scrolled;
    logic            busy;
    logic            out_free;
  } tcw_stat_t;

endpackage

/* rtl/tcw_ctrl.sv */
// Sequencing state machine of the text console writer.
module tcw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  tcw_pkg::tcw_stat_t stat_i,
  output tcw_pkg::tcw_cmd_t  cmd_o
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT      = 3'd0;
  localparam logic [2:0] S_INIT_WAIT = 3'd1;
  localparam logic [2:0] S_IDLE      = 3'd2;
  localparam logic [2:0] S_EXEC      = 3'd3;
  localparam logic [2:0] S_PUT_CHK   = 3'd4;
  localparam logic [2:0] S_SWEEP     = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sweep_kind = SWEEP_INIT;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_start = 1'b1;
        cmd_o.sweep_kind  = SWEEP_INIT;
        state_d = S_INIT_WAIT;
      end
      S_INIT_WAIT: begin
        if (!stat_i.busy) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat_i.op)
          OP_PUT: begin
            cmd_o.put_exec = 1'b1;
            state_d = S_PUT_CHK;
          end
          OP_CLEAR: begin
            cmd_o.clear_cur   = 1'b1;
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_kind  = SWEEP_CLEAR;
            state_d = S_SWEEP;
          end
          OP_READ: begin
            cmd_o.read_issue = 1'b1;
            state_d = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_PUT_CHK: begin
        if (stat_i.scrolled) begin
          cmd_o.sweep_start = 1'b1;
          cmd_o.sweep_kind  = SWEEP_SCROLL;
          state_d = S_SWEEP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SWEEP: begin
        if (!stat_i.busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

endmodule

/* rtl/tcw_datapath.sv */
// Cell memory, cursor, sweep engine and result register of the text console writer.
module tcw_datapath #(
  parameter int ROWS = tcw_pkg::DEF_ROWS,
  parameter int COLS = tcw_pkg::DEF_COLS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::BYTE_W-1:0]  cfg_wdata_i,
  input  logic [tcw_pkg::OP_W-1:0]    in_op_i,
  input  logic [tcw_pkg::BYTE_W-1:0]  in_char_i,
  input  logic [tcw_pkg::BYTE_W-1:0]  in_attr_i,
  input  logic [tcw_pkg::IDX_W-1:0]   in_idx_i,
  input  tcw_pkg::tcw_cmd_t           cmd_i,
  output tcw_pkg::tcw_stat_t          stat_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tcw_pkg::IDX_W-1:0]   out_cursor_o,
  output logic [tcw_pkg::BYTE_W-1:0]  out_char_o,
  output logic [tcw_pkg::BYTE_W-1:0]  out_attr_o,
  output logic                        out_scrolled_o
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int BW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLS);
  localparam int CELL_W = 2 * BYTE_W;
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] MOVE_END  = AW'(CELLS - COLS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLS);
  localparam logic [BW-1:0] BASE_STEP = BW'(COLS);
  localparam logic [BW-1:0] BASE_END  = BW'(CELLS);
  localparam logic [BW-1:0] BASE_LAST = BW'(CELLS - COLS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);

  logic [CELL_W-1:0] ram_q [CELLS];
  logic [CELL_W-1:0] rd_data_q;

  logic [OP_W-1:0]   op_q;
  logic [BYTE_W-1:0] char_q, attr_q;
  logic [IDX_W-1:0]  idx_q;
  logic [BYTE_W-1:0] def_attr_q;
  logic [BW-1:0]     base_q, base_d;
  logic [CW-1:0]     col_q, col_d;
  logic              scrolled_q;

  logic              sw_active_q, sw_active_d;
  logic [AW-1:0]     sw_cnt_q, sw_cnt_d;
  logic              sw_move_q, sw_move_d;
  logic [CELL_W-1:0] fill_q, fill_d;
  logic              wr_valid_q, wr_valid_d;
  logic [AW-1:0]     wr_idx_q, wr_idx_d;
  logic              wr_use_rd_q, wr_use_rd_d;

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_cursor_q;
  logic [BYTE_W-1:0] out_char_q, out_attr_q;
  logic              out_scrolled_q;

  logic [AW-1:0]     pos;
  logic [BYTE_W-1:0] put_attr;
  logic              put_we;
  logic [AW-1:0]     put_addr;
  logic [CELL_W-1:0] put_data;
  logic [BW-1:0]     nbase;
  logic [CW-1:0]     ncol;
  logic              wrap;
  logic              sw_below;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [CELL_W-1:0] mem_wd;
  logic              idx_ok;
  logic [31:0]       cur_wide;

  assign pos      = AW'(base_q) + AW'(col_q);
  assign put_attr = (attr_q == '0) ? def_attr_q : attr_q;

  always_comb begin
    nbase    = base_q;
    ncol     = col_q;
    put_we   = 1'b0;
    put_addr = pos;
    put_data = {put_attr, char_q};
    case (char_q)
      CH_NEWLINE: begin
        nbase = base_q + BASE_STEP;
        ncol  = '0;
      end
      CH_RETURN: begin
        ncol = '0;
      end
      CH_BACKSPACE: begin
        if (pos != '0) begin
          put_we   = 1'b1;
          put_addr = pos - AW'(1);
          put_data = {put_attr, CH_SPACE};
          if (col_q == '0) begin
            nbase = base_q - BASE_STEP;
            ncol  = COL_LAST;
          end else begin
            ncol = col_q - CW'(1);
          end
        end
      end
      default: begin
        put_we = 1'b1;
        if (col_q == COL_LAST) begin
          nbase = base_q + BASE_STEP;
          ncol  = '0;
        end else begin
          ncol = col_q + CW'(1);
        end
      end
    endcase
    wrap = (nbase == BASE_END);
    if (wrap) begin
      nbase = BASE_LAST;
    end
  end

  always_comb begin
    base_d = base_q;
    col_d  = col_q;
    if (cmd_i.clear_cur) begin
      base_d = '0;
      col_d  = '0;
    end else if (cmd_i.put_exec) begin
      base_d = nbase;
      col_d  = ncol;
    end
  end

  assign sw_below = sw_move_q && (sw_cnt_q < MOVE_END);

  always_comb begin
    sw_active_d = sw_active_q;
    sw_cnt_d    = sw_cnt_q;
    sw_move_d   = sw_move_q;
    fill_d      = fill_q;
    wr_valid_d  = 1'b0;
    wr_idx_d    = sw_cnt_q;
    wr_use_rd_d = sw_below;
    if (cmd_i.sweep_start) begin
      sw_active_d = 1'b1;
      sw_cnt_d    = '0;
      sw_move_d   = (cmd_i.sweep_kind == SWEEP_SCROLL);
      fill_d      = (cmd_i.sweep_kind == SWEEP_CLEAR) ? {def_attr_q, CH_SPACE} : '0;
    end else if (sw_active_q) begin
      wr_valid_d = 1'b1;
      if (sw_cnt_q == LAST_CELL) begin
        sw_active_d = 1'b0;
      end else begin
        sw_cnt_d = sw_cnt_q + AW'(1);
      end
    end
  end

  always_comb begin
    mem_we = wr_valid_q || (cmd_i.put_exec && put_we);
    mem_wa = wr_valid_q ? wr_idx_q : put_addr;
    mem_wd = wr_valid_q ? (wr_use_rd_q ? rd_data_q : fill_q) : put_data;
    mem_re = cmd_i.read_issue || (sw_active_q && sw_below);
    mem_ra = cmd_i.read_issue ? AW'(idx_q) : sw_cnt_q + ROW_STEP;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ram_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= ram_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q   <= in_op_i;
      char_q <= in_char_i;
      attr_q <= in_attr_i;
      idx_q  <= in_idx_i;
    end
    if (cmd_i.sweep_start) begin
      fill_q <= fill_d;
    end
    wr_idx_q    <= wr_idx_d;
    wr_use_rd_q <= wr_use_rd_d;
    sw_cnt_q    <= sw_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_attr_q  <= DEF_ATTR;
      base_q      <= '0;
      col_q       <= '0;
      scrolled_q  <= 1'b0;
      sw_active_q <= 1'b0;
      sw_move_q   <= 1'b0;
      wr_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        def_attr_q <= cfg_wdata_i;
      end
      base_q      <= base_d;
      col_q       <= col_d;
      sw_active_q <= sw_active_d;
      sw_move_q   <= sw_move_d;
      wr_valid_q  <= wr_valid_d;
      if (cmd_i.in_load) begin
        scrolled_q <= 1'b0;
      end else if (cmd_i.put_exec) begin
        scrolled_q <= wrap;
      end
    end
  end

  assign idx_ok   = (32'(idx_q) < CELLS);
  assign cur_wide = 32'(pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      out_cursor_q   <= cur_wide[IDX_W-1:0];
      out_scrolled_q <= (op_q == OP_PUT) && scrolled_q;
      if ((op_q == OP_READ) && idx_ok) begin
        out_char_q <= rd_data_q[BYTE_W-1:0];
        out_attr_q <= rd_data_q[CELL_W-1:BYTE_W];
      end else begin
        out_char_q <= '0;
        out_attr_q <= '0;
      end
    end
  end

  assign stat_o.op       = op_q;
  assign stat_o.scrolled = scrolled_q;
  assign stat_o.busy     = sw_active_q || wr_valid_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_cursor_o   = out_cursor_q;
  assign out_char_o     = out_char_q;
  assign out_attr_o     = out_attr_q;
  assign out_scrolled_o = out_scrolled_q;

endmodule

/* rtl/text_console_writer_unit.sv */
// Top level of the text console writer: stream ports, controller and datapath.
//
//  channel   | direction | handshake                    | content
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | one request: put, clear or read
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | one result per request
//  cfg       | in        | cfg_we_i                     | default attribute
//
// A put that scrolls, and every clear, sweeps the whole cell memory: its single
// write port moves one cell per cycle. After reset a clearing pass zeroes the
// memory; no request is taken meanwhile. A finished result waits in the output
// register, and the next request is accepted while it waits.
module text_console_writer_unit #(
  parameter int ROWS = tcw_pkg::DEF_ROWS,
  parameter int COLS = tcw_pkg::DEF_COLS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tcw_pkg::BYTE_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // char_code [7:0], char_attr [15:8], cell_index [26:16], zero above
  input  logic [tcw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation [1:0]
  input  logic [tcw_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // cursor_position [10:0], cell_char [18:11], cell_attr [26:19], scrolled [27]
  output logic [tcw_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import tcw_pkg::*;

  tcw_cmd_t          cmd;
  tcw_stat_t         stat;
  logic [IDX_W-1:0]  out_cursor;
  logic [BYTE_W-1:0] out_char, out_attr;
  logic              out_scrolled;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tcw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_op_i        (s_axis_tuser),
    .in_char_i      (s_axis_tdata[7:0]),
    .in_attr_i      (s_axis_tdata[15:8]),
    .in_idx_i       (s_axis_tdata[26:16]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_cursor_o   (out_cursor),
    .out_char_o     (out_char),
    .out_attr_o     (out_attr),
    .out_scrolled_o (out_scrolled)
  );

  assign m_axis_tdata = {4'b0000, out_scrolled, out_attr, out_char, out_cursor};

endmodule
